/* rtl/core/pfba_pkg.sv */
// Shared types and constants of the paged fixed block allocator.
// Used by the page table, the link memory and the top level; no dependencies.
package pfba_pkg;

  localparam int unsigned MaxPages   = 16;
  localparam int unsigned MaxBlocks  = 64;
  localparam int unsigned PageW      = $clog2(MaxPages);
  localparam int unsigned BlockW     = $clog2(MaxBlocks);
  localparam int unsigned CountW     = BlockW + 1;
  localparam int unsigned OpenW      = PageW + 1;
  localparam int unsigned LinkAddrW  = PageW + BlockW;
  localparam int unsigned LinkW      = BlockW + 1;
  localparam int unsigned LinkDepth  = MaxPages * MaxBlocks;

  localparam int unsigned BlockSizeW = 13;
  localparam int unsigned BppW       = 7;
  localparam int unsigned OffsetW    = 18;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 3;

  localparam logic [BlockSizeW-1:0] BlockSizeRst     = 13'd16;
  localparam logic [BppW-1:0]       BlocksPerPageRst = 7'd10;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic RegBlockSize     = 1'b0;
  localparam logic RegBlocksPerPage = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_OOM    = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    UPD_NONE = 3'd0,
    UPD_PUSH = 3'd1,
    UPD_POP  = 3'd2,
    UPD_INIT = 3'd3,
    UPD_OPEN = 3'd4
  } upd_kind_e;

  typedef struct packed {
    upd_kind_e           kind;
    logic [PageW-1:0]    page;
    logic [BlockW-1:0]   head;
    logic                head_valid;
    logic [CountW-1:0]   init;
  } pt_upd_t;

  typedef struct packed {
    logic                found;
    logic                use_list;
    logic [PageW-1:0]    page;
    logic                can_open;
    logic [PageW-1:0]    open_page;
  } pt_search_t;

  typedef struct packed {
    logic                page_open;
    logic                head_valid;
    logic [BlockW-1:0]   head;
    logic [CountW-1:0]   init;
  } pt_entry_t;

endpackage

/* rtl/core/pfba_link_mem.sv */
// Free-list link memory: one link word per block of every page.
// Synchronous RAM with one write and one registered read port; uses pfba_pkg.
module pfba_link_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pfba_pkg::LinkAddrW-1:0] waddr_i,
  input  logic [pfba_pkg::LinkW-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [pfba_pkg::LinkAddrW-1:0] raddr_i,
  output logic [pfba_pkg::LinkW-1:0]     rdata_o
);

  logic [pfba_pkg::LinkW-1:0] mem_q [pfba_pkg::LinkDepth];
  logic [pfba_pkg::LinkW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pfba_page_table.sv */
// Per-page state: free-list head, init count and the open page count,
// with the in-order search for the first page that can serve. Uses pfba_pkg.
module pfba_page_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pfba_pkg::CountW-1:0]  bpp_i,
  input  logic [pfba_pkg::PageW-1:0]   rd_page_i,
  input  pfba_pkg::pt_upd_t            upd_i,
  output pfba_pkg::pt_search_t         search_o,
  output pfba_pkg::pt_entry_t          entry_o
);

  logic [pfba_pkg::BlockW-1:0] head_q  [pfba_pkg::MaxPages];
  logic [pfba_pkg::CountW-1:0] init_q  [pfba_pkg::MaxPages];
  logic [pfba_pkg::MaxPages-1:0] hvalid_q;
  logic [pfba_pkg::OpenW-1:0]  pages_open_q;
  logic [pfba_pkg::MaxPages-1:0] cand;

  always_comb begin
    for (int p = 0; p < pfba_pkg::MaxPages; p++) begin
      cand[p] = (pfba_pkg::OpenW'(p) < pages_open_q) && (hvalid_q[p] || (init_q[p] < bpp_i));
    end
  end

  always_comb begin
    search_o.found    = 1'b0;
    search_o.use_list = 1'b0;
    search_o.page     = '0;
    for (int p = pfba_pkg::MaxPages - 1; p >= 0; p--) begin
      if (cand[p]) begin
        search_o.found    = 1'b1;
        search_o.use_list = hvalid_q[p];
        search_o.page     = pfba_pkg::PageW'(p);
      end
    end
    search_o.can_open  = pages_open_q < pfba_pkg::OpenW'(pfba_pkg::MaxPages);
    search_o.open_page = pages_open_q[pfba_pkg::PageW-1:0];
  end

  assign entry_o.page_open  = {1'b0, rd_page_i} < pages_open_q;
  assign entry_o.head_valid = hvalid_q[rd_page_i];
  assign entry_o.head       = head_q[rd_page_i];
  assign entry_o.init       = init_q[rd_page_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_open_q <= pfba_pkg::OpenW'(1);
      hvalid_q     <= '0;
      for (int p = 0; p < pfba_pkg::MaxPages; p++) begin
        head_q[p] <= '0;
        init_q[p] <= '0;
      end
    end else begin
      case (upd_i.kind)
        pfba_pkg::UPD_NONE: begin
        end
        pfba_pkg::UPD_PUSH, pfba_pkg::UPD_POP: begin
          head_q[upd_i.page]   <= upd_i.head;
          hvalid_q[upd_i.page] <= upd_i.head_valid;
        end
        pfba_pkg::UPD_INIT: begin
          init_q[upd_i.page] <= upd_i.init;
        end
        pfba_pkg::UPD_OPEN: begin
          head_q[upd_i.page]   <= upd_i.head;
          hvalid_q[upd_i.page] <= upd_i.head_valid;
          init_q[upd_i.page]   <= upd_i.init;
          pages_open_q         <= pages_open_q + pfba_pkg::OpenW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/paged_fixed_block_allocator.sv */
// Top level of the paged fixed block allocator: command channel, APB-style
// register port and the request sequencer. Uses pfba_pkg, pfba_page_table, pfba_link_mem.
//
// A request is taken at a clock edge with start high and busy low. operation 0
// allocates a block; operation 1 frees the block free_block of page free_page.
// Every request gives exactly one result word, shown for one cycle with done_o
// high: status_o, page_index_o, block_index_o and byte_offset_o.
// A free, or an allocation served from a fresh block or a new page, passes
// through the decide and emit steps, and done_o is registered from emit; an
// allocation that pops a free list adds a pop step between them, as the link of
// the popped block comes from the registered read of the link memory. busy stays
// high through these steps; a new request may be given in the cycle in which
// done_o is high. The receiver cannot stall, so results are never held.
// Registers: block_size at address 0 and blocks_per_page at address 4. The
// user must write them only while busy is low; the block does not enforce it.
// Reset opens page 0 with empty free lists, clears all init counts and loads
// block_size 16 and blocks_per_page 10; the link memory needs no clearing.
module paged_fixed_block_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation_i,
  input  logic [pfba_pkg::PageW-1:0]       free_page_i,
  input  logic [pfba_pkg::BlockW-1:0]      free_block_i,
  output logic                             done_o,
  output logic [pfba_pkg::StatusW-1:0]     status_o,
  output logic [pfba_pkg::PageW-1:0]       page_index_o,
  output logic [pfba_pkg::BlockW-1:0]      block_index_o,
  output logic [pfba_pkg::OffsetW-1:0]     byte_offset_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfba_pkg::AddrW-1:0]       paddr,
  input  logic [pfba_pkg::DataW-1:0]       pwdata,
  output logic [pfba_pkg::DataW-1:0]       prdata,
  output logic                             pready
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_POP    = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [pfba_pkg::BlockSizeW-1:0] block_size_q;
  logic [pfba_pkg::BppW-1:0]       bpp_q;
  logic [pfba_pkg::CountW-1:0]     bpp_eff;

  logic                            op_q;
  logic [pfba_pkg::PageW-1:0]      fp_q;
  logic [pfba_pkg::BlockW-1:0]     fb_q;

  pfba_pkg::status_e               res_status_q, res_status_d;
  logic [pfba_pkg::PageW-1:0]      res_page_q, res_page_d;
  logic [pfba_pkg::BlockW-1:0]     res_blk_q, res_blk_d;

  logic                            done_q;
  logic [pfba_pkg::StatusW-1:0]    status_q;
  logic [pfba_pkg::PageW-1:0]      page_q;
  logic [pfba_pkg::BlockW-1:0]     blk_q;
  logic [pfba_pkg::OffsetW-1:0]    offset_q;
  logic [pfba_pkg::BlockW+pfba_pkg::BlockSizeW-1:0] product;

  pfba_pkg::pt_upd_t               upd;
  pfba_pkg::pt_search_t            srch;
  pfba_pkg::pt_entry_t             entry;
  logic [pfba_pkg::PageW-1:0]      rd_page;

  logic                            link_we;
  logic [pfba_pkg::LinkAddrW-1:0]  link_waddr;
  logic [pfba_pkg::LinkW-1:0]      link_wdata;
  logic                            link_re;
  logic [pfba_pkg::LinkAddrW-1:0]  link_raddr;
  logic [pfba_pkg::LinkW-1:0]      link_rdata;

  logic                            cfg_write;
  logic                            accept;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign busy      = state_q != ST_IDLE;
  assign accept    = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= pfba_pkg::BlockSizeRst;
      bpp_q        <= pfba_pkg::BlocksPerPageRst;
    end else if (cfg_write) begin
      case (paddr[2])
        pfba_pkg::RegBlockSize: block_size_q <= pwdata[pfba_pkg::BlockSizeW-1:0];
        default:                bpp_q        <= pwdata[pfba_pkg::BppW-1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pfba_pkg::RegBlockSize: prdata = pfba_pkg::DataW'(block_size_q);
      default:                prdata = pfba_pkg::DataW'(bpp_q);
    endcase
  end

  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = pfba_pkg::CountW'(1);
    end else if (pfba_pkg::BppW'(bpp_q) > pfba_pkg::BppW'(pfba_pkg::MaxBlocks)) begin
      bpp_eff = pfba_pkg::CountW'(pfba_pkg::MaxBlocks);
    end else begin
      bpp_eff = pfba_pkg::CountW'(bpp_q);
    end
  end

  assign rd_page = (op_q == pfba_pkg::OpFree) ? fp_q : srch.page;

  pfba_page_table u_page_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bpp_i     (bpp_eff),
    .rd_page_i (rd_page),
    .upd_i     (upd),
    .search_o  (srch),
    .entry_o   (entry)
  );

  pfba_link_mem u_link_mem (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    res_blk_d    = res_blk_q;
    upd          = '{kind: pfba_pkg::UPD_NONE, page: '0, head: '0, head_valid: 1'b0, init: '0};
    link_we      = 1'b0;
    link_waddr   = {fp_q, fb_q};
    link_wdata   = {entry.head_valid, entry.head};
    link_re      = 1'b0;
    link_raddr   = {srch.page, entry.head};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d      = ST_EMIT;
        res_status_d = pfba_pkg::STATUS_OK;
        res_page_d   = '0;
        res_blk_d    = '0;
        if (op_q == pfba_pkg::OpFree) begin
          if (!entry.page_open || (pfba_pkg::CountW'(fb_q) >= bpp_eff)) begin
            res_status_d = pfba_pkg::STATUS_REJECT;
          end else begin
            link_we         = 1'b1;
            upd.kind        = pfba_pkg::UPD_PUSH;
            upd.page        = fp_q;
            upd.head        = fb_q;
            upd.head_valid  = 1'b1;
          end
        end else if (srch.found) begin
          res_page_d = srch.page;
          if (srch.use_list) begin
            link_re   = 1'b1;
            res_blk_d = entry.head;
            state_d   = ST_POP;
          end else begin
            res_blk_d = entry.init[pfba_pkg::BlockW-1:0];
            upd.kind  = pfba_pkg::UPD_INIT;
            upd.page  = srch.page;
            upd.init  = entry.init + pfba_pkg::CountW'(1);
          end
        end else if (srch.can_open) begin
          res_page_d     = srch.open_page;
          upd.kind       = pfba_pkg::UPD_OPEN;
          upd.page       = srch.open_page;
          upd.head       = '0;
          upd.head_valid = 1'b0;
          upd.init       = pfba_pkg::CountW'(1);
        end else begin
          res_status_d = pfba_pkg::STATUS_OOM;
        end
      end
      ST_POP: begin
        upd.kind       = pfba_pkg::UPD_POP;
        upd.page       = res_page_q;
        upd.head       = link_rdata[pfba_pkg::BlockW-1:0];
        upd.head_valid = link_rdata[pfba_pkg::BlockW];
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign product = {{pfba_pkg::BlockSizeW{1'b0}}, res_blk_q}
                 * {{pfba_pkg::BlockW{1'b0}}, block_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == ST_EMIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      fp_q <= free_page_i;
      fb_q <= free_block_i;
    end
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    res_blk_q    <= res_blk_d;
    if (state_q == ST_EMIT) begin
      status_q <= res_status_q;
      page_q   <= res_page_q;
      blk_q    <= res_blk_q;
      offset_q <= product[pfba_pkg::OffsetW-1:0];
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign page_index_o  = page_q;
  assign block_index_o = blk_q;
  assign byte_offset_o = offset_q;

`ifndef ASSERT_OFF
  a_accept_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DECIDE)
    else $error("accepted word did not enter the decide step");

  a_done_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without an emit step");

  a_oom_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == pfba_pkg::STATUS_OOM)) |-> !srch.can_open)
    else $error("out of memory reported while a page could still be opened");

  a_pop_reads_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> $past(link_re))
    else $error("free-list pop without a link read");
`endif

endmodule
